[hdl/divisible_subarray_counter_core_assert.svh]
// Assertion macros used by the checker file of the counter core.
`ifndef DIVISIBLE_SUBARRAY_COUNTER_CORE_ASSERT_SVH
`define DIVISIBLE_SUBARRAY_COUNTER_CORE_ASSERT_SVH

// Generic clocked assertion with an active-low disable.
`define DSC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Assertion on the core clock and reset.
`define DSC_ASSERT(lbl, prop, msg) \
    `DSC_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

[hdl/dsc_pkg.sv]
package dsc_pkg;

    localparam int VALUE_W   = 32;
    localparam int TOTAL_W   = 48;
    localparam int MOD_W     = 13;
    localparam int DIV_W     = VALUE_W + 1;
    localparam int EPOCH_W   = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [MOD_W-1:0]     MOD_RESET    = 13'd1;
    localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 1'b0;

    typedef struct packed {
        logic accept;
        logic sweep_step;
        logic div_step;
        logic mem_read;
        logic update;
    } dsc_cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
        logic div_last;
        logic out_free;
    } dsc_sts_t;

endpackage

[hdl/dsc_cfg_regs.sv]
module dsc_cfg_regs #(
    parameter int MAX_MODULUS = 4096,
    localparam int MW = $clog2(MAX_MODULUS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [MW-1:0]                eff_modulus
);
    import dsc_pkg::*;

    logic [MOD_W-1:0]     modulus_reg, modulus_next;
    logic [MW-1:0]        eff_modulus_reg, eff_modulus_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          mod_ext;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign mod_ext = 32'(modulus_reg);

    always_comb begin
        modulus_next = modulus_reg;
        if (wr_en && (reg_idx == REG_MODULUS)) begin
            modulus_next = pwdata[MOD_W-1:0];
        end
    end

    // Clamp to the supported range: zero acts as one.
    always_comb begin
        priority if (modulus_reg == '0) begin
            eff_modulus_next = MW'(1);
        end else if (mod_ext > 32'(MAX_MODULUS)) begin
            eff_modulus_next = MW'(MAX_MODULUS);
        end else begin
            eff_modulus_next = MW'(modulus_reg);
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODULUS: prdata = PDATA_W'(modulus_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= MOD_RESET;
            eff_modulus_reg <= MW'(1);
        end else begin
            modulus_reg     <= modulus_next;
            eff_modulus_reg <= eff_modulus_next;
        end
    end

    assign eff_modulus = eff_modulus_reg;

endmodule

[hdl/dsc_ctrl.sv]
module dsc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dsc_pkg::dsc_sts_t sts,
    output dsc_pkg::dsc_cmd_t cmd
);
    import dsc_pkg::*;

    localparam logic [2:0] ST_INIT_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE       = 3'd1;
    localparam logic [2:0] ST_SEQ_SWEEP  = 3'd2;
    localparam logic [2:0] ST_DIV        = 3'd3;
    localparam logic [2:0] ST_READ       = 3'd4;
    localparam logic [2:0] ST_UPDATE     = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.need_sweep ? ST_SEQ_SWEEP : ST_DIV;
                end
            end
            ST_SEQ_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/dsc_datapath.sv]
module dsc_datapath #(
    parameter int MAX_MODULUS     = 4096,
    parameter int MAX_LENGTH_BITS = 20,
    localparam int MW = $clog2(MAX_MODULUS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dsc_pkg::dsc_cmd_t             cmd,
    output dsc_pkg::dsc_sts_t             sts,
    input  logic [dsc_pkg::VALUE_W-1:0]   s_value,
    input  logic                          s_first,
    input  logic                          s_last,
    input  logic [MW-1:0]                 eff_modulus,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [dsc_pkg::TOTAL_W-1:0]   m_run_count,
    output logic                          m_final_res
);
    import dsc_pkg::*;

    localparam int RW    = $clog2(MAX_MODULUS);
    localparam int BW    = MAX_LENGTH_BITS + 1;
    localparam int MEM_W = EPOCH_W + BW;
    localparam int CNT_W = $clog2(DIV_W);

    logic [MEM_W-1:0] hist_mem [MAX_MODULUS];

    logic [RW-1:0]      prefix_reg, prefix_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [RW-1:0]      sweep_cnt_reg, sweep_cnt_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]   num_reg, num_next;
    logic [MW-1:0]      rem_reg, rem_next;
    logic               last_reg, last_next;
    logic [MEM_W-1:0]   rd_data_reg;
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] m_run_count_reg, m_run_count_next;
    logic               m_final_res_reg, m_final_res_next;

    logic [MW:0]        shifted;
    logic [MW:0]        mod_ext;
    logic [RW-1:0]      residue;
    logic [EPOCH_W-1:0] entry_tag;
    logic [BW-1:0]      entry_cnt;
    logic [BW-1:0]      bin_cnt;
    logic [BW-1:0]      bin_new;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] total_upd;
    logic               wr_en;
    logic [RW-1:0]      wr_addr;
    logic [MEM_W-1:0]   wr_data;

    assign residue   = rem_reg[RW-1:0];
    assign mod_ext   = {1'b0, eff_modulus};
    assign shifted   = {rem_reg, num_reg[DIV_W-1]};
    assign entry_tag = rd_data_reg[MEM_W-1:BW];
    assign entry_cnt = rd_data_reg[BW-1:0];

    assign sts.need_sweep = s_first & (epoch_reg == '1);
    assign sts.sweep_last = (sweep_cnt_reg == RW'(MAX_MODULUS - 1));
    assign sts.div_last   = (div_cnt_reg == CNT_W'(DIV_W - 1));
    assign sts.out_free   = ~m_valid_reg | m_ready;

    // Bin lookup: a stale tag means the bin was never hit in this sequence.
    always_comb begin
        if (entry_tag == epoch_reg) begin
            bin_cnt = entry_cnt;
        end else begin
            bin_cnt = BW'(residue == '0);
        end
        bin_new   = (bin_cnt != '1) ? bin_cnt + BW'(1) : bin_cnt;
        sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(bin_cnt);
        total_upd = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end

    always_comb begin
        prefix_next      = prefix_reg;
        total_next       = total_reg;
        epoch_next       = epoch_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        div_cnt_next     = div_cnt_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        last_next        = last_reg;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_run_count_next = m_run_count_reg;
        m_final_res_next = m_final_res_reg;

        if (cmd.accept) begin
            num_next     = DIV_W'(s_value) + DIV_W'(s_first ? '0 : prefix_reg);
            rem_next     = '0;
            div_cnt_next = '0;
            last_next    = s_last;
            if (s_first) begin
                total_next = '0;
                if (epoch_reg != '1) begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                end
            end
        end

        if (cmd.sweep_step) begin
            if (sts.sweep_last) begin
                sweep_cnt_next = '0;
                epoch_next     = EPOCH_W'(1);
            end else begin
                sweep_cnt_next = sweep_cnt_reg + RW'(1);
            end
        end

        // Restoring remainder, one dividend bit per step.
        if (cmd.div_step) begin
            if (shifted >= mod_ext) begin
                rem_next = MW'(shifted - mod_ext);
            end else begin
                rem_next = MW'(shifted);
            end
            num_next     = num_reg << 1;
            div_cnt_next = div_cnt_reg + CNT_W'(1);
        end

        if (cmd.mem_read) begin
            prefix_next = residue;
        end

        if (cmd.update) begin
            total_next       = total_upd;
            m_valid_next     = 1'b1;
            m_run_count_next = total_upd;
            m_final_res_next = last_reg;
        end
    end

    always_comb begin
        wr_en = cmd.sweep_step | cmd.update;
        if (cmd.sweep_step) begin
            wr_addr = sweep_cnt_reg;
            wr_data = '0;
        end else begin
            wr_addr = residue;
            wr_data = {epoch_reg, bin_new};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_read) begin
            rd_data_reg <= hist_mem[residue];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg    <= '0;
            total_reg     <= '0;
            epoch_reg     <= EPOCH_W'(1);
            sweep_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            prefix_reg    <= prefix_next;
            total_reg     <= total_next;
            epoch_reg     <= epoch_next;
            sweep_cnt_reg <= sweep_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_cnt_reg     <= div_cnt_next;
        num_reg         <= num_next;
        rem_reg         <= rem_next;
        last_reg        <= last_next;
        m_run_count_reg <= m_run_count_next;
        m_final_res_reg <= m_final_res_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_run_count = m_run_count_reg;
    assign m_final_res = m_final_res_reg;

endmodule

[hdl/divisible_subarray_counter_core.sv]
// Each input transaction takes 33 remainder steps, one histogram read and one update
// that waits for a free result slot; the next transaction is taken after the update.
// The bit-serial remainder unit reduces one dividend bit a cycle.
// Reset is synchronous, active low: after release all MAX_MODULUS histogram entries
// are swept with s_ready low. Every 255th first-flagged sequence adds a sweep of
// the whole histogram before that transaction is processed.
module divisible_subarray_counter_core #(
    parameter int MAX_MODULUS     = 4096,
    parameter int MAX_LENGTH_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input transaction channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dsc_pkg::VALUE_W-1:0]  s_value,
    input  logic                         s_first,
    input  logic                         s_last,
    // result transaction channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dsc_pkg::TOTAL_W-1:0]  m_run_count,
    output logic                         m_final_res,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import dsc_pkg::*;

    localparam int MW = $clog2(MAX_MODULUS + 1);

    dsc_cmd_t      cmd;
    dsc_sts_t      sts;
    logic [MW-1:0] eff_modulus;

    // Modulus register; hold a clamped copy for the remainder unit.
    dsc_cfg_regs #(
        .MAX_MODULUS (MAX_MODULUS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .eff_modulus (eff_modulus)
    );

    // Sequencer: sweep, accept, reduce, read bin, update and post the result.
    // The next transaction is taken while a posted result still waits.
    dsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Remainder unit, residue histogram with epoch tags, saturating total and
    // the output register.
    dsc_datapath #(
        .MAX_MODULUS     (MAX_MODULUS),
        .MAX_LENGTH_BITS (MAX_LENGTH_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_value     (s_value),
        .s_first     (s_first),
        .s_last      (s_last),
        .eff_modulus (eff_modulus),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_run_count (m_run_count),
        .m_final_res (m_final_res)
    );

endmodule

[hdl/dsc_checker.sv]
`include "divisible_subarray_counter_core_assert.svh"

module dsc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [dsc_pkg::TOTAL_W-1:0]  m_run_count
);

    `DSC_ASSERT(a_out_hold, (m_valid && !m_ready) |=> m_valid, "result dropped while stalled")
    `DSC_ASSERT(a_out_stable, (m_valid && !m_ready) |=> $stable(m_run_count), "stalled count changed")
    `DSC_ASSERT(a_one_at_a_time, (s_valid && s_ready) |=> !s_ready, "second transaction taken early")
    `DSC_ASSERT(a_no_instant_result, $rose(m_valid) |-> !$past(s_valid && s_ready), "result too early")

endmodule

bind divisible_subarray_counter_core dsc_checker u_dsc_checker (.*);

[tb/divisible_subarray_counter_core_test.sv]
module divisible_subarray_counter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              MAX_MOD    = 4096;
    localparam int              LEN_BITS   = 20;
    localparam logic [47:0]     TOTAL_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam longint unsigned BIN_MAX    = (64'd1 << (LEN_BITS + 1)) - 1;
    localparam int              IDLE_PCT   = 28;
    localparam int              HOLDOFF    = 400;
    localparam int              SETTLE     = 40;

    localparam logic [dsc_pkg::PADDR_W-1:0] MODULUS_ADDR = {dsc_pkg::REG_MODULUS, 2'b00};

    typedef struct {
        logic [31:0] value;
        logic        first;
        logic        last;
    } seq_item_t;

    typedef struct {
        logic [47:0] run_count;
        logic        final_res;
    } run_result_t;

    // clock, reset and block ports; every input starts at a known value
    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [dsc_pkg::VALUE_W-1:0]   s_value     = '0;
    logic                          s_first     = 1'b0;
    logic                          s_last      = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [dsc_pkg::TOTAL_W-1:0]   m_run_count;
    logic                          m_final_res;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [dsc_pkg::PADDR_W-1:0]   paddr       = '0;
    logic [dsc_pkg::PDATA_W-1:0]   pwdata      = '0;
    logic [dsc_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // shadow of the block's state, advanced once per accepted transaction
    logic [dsc_pkg::MOD_W-1:0]     cur_modulus = dsc_pkg::MOD_RESET;
    logic [11:0]                   residue     = '0;
    logic [47:0]                   pair_sum    = '0;
    logic [LEN_BITS:0]             bin_count [MAX_MOD];
    logic [MAX_MOD-1:0]            bin_seen    = '0;

    seq_item_t                     pending_items[$];
    run_result_t                   expected_counts[$];
    seq_item_t                     offer;

    int  queued_count   = 0;
    int  accepted_count = 0;
    int  checked_count  = 0;
    int  error_count    = 0;
    int  seq_count      = 0;
    int  setting_count  = 0;
    int  holdoff_left   = 0;
    bit  steady_flow    = 1'b0;
    bit  press_armed    = 1'b0;
    bit  press_taken    = 1'b0;

    divisible_subarray_counter_core #(
        .MAX_MODULUS    (MAX_MOD),
        .MAX_LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_first    (s_first),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_run_count(m_run_count),
        .m_final_res(m_final_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 aclk = ~aclk;

    // Zero behaves as one, anything past the histogram size clamps to it.
    function automatic int unsigned effective_mod(input logic [dsc_pkg::MOD_W-1:0] raw);
        int unsigned m;
        m = raw;
        if (m == 0) m = 1;
        if (m > MAX_MOD) m = MAX_MOD;
        return m;
    endfunction

    // Advance the shadow state by one element and queue the running total it yields.
    function automatic void tally_item(input seq_item_t it);
        longint unsigned m;
        longint unsigned r;
        longint unsigned cnt;
        run_result_t     res;
        m = effective_mod(cur_modulus);
        if (it.first) begin
            bin_seen = '0;
            residue  = '0;
            pair_sum = '0;
        end
        // old residue may exceed the new modulus after a mid-sequence change
        r = (longint'(residue) + (longint'(it.value) % m)) % m;
        residue = r[11:0];
        cnt = bin_seen[r] ? longint'(bin_count[r]) : ((r == 0) ? 1 : 0);
        if (longint'(pair_sum) > longint'(TOTAL_MAX) - cnt) pair_sum = TOTAL_MAX;
        else pair_sum = pair_sum + cnt[47:0];
        if (cnt < BIN_MAX) cnt = cnt + 1;
        bin_count[r] = cnt[LEN_BITS:0];
        bin_seen[r]  = 1'b1;
        res.run_count = pair_sum;
        res.final_res = it.last;
        expected_counts.push_back(res);
    endfunction

    // Mix small values, exact multiples and wide patterns so residue zero hits often.
    function automatic logic [31:0] pick_value(input int unsigned m);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return 32'($urandom_range(0, 2 * m));
        else if (sel < 50) return 32'(m * $urandom_range(0, 16));
        else if (sel < 75) return $urandom();
        else if (sel < 85) return 32'h0;
        else if (sel < 92) return 32'hFFFF_FFFF;
        else return 32'hFFFF_FFFF - 32'($urandom_range(0, 3 * m));
    endfunction

    task automatic queue_item(input logic [31:0] value, input logic first, input logic last);
        seq_item_t it;
        it.value = value;
        it.first = first;
        it.last  = last;
        if (first) seq_count++;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODULUS_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_modulus_reg(input logic [dsc_pkg::MOD_W-1:0] want);
        logic [31:0] rd;
        apb_xfer(1'b0, 32'h0, rd);
        if (rd !== {{(32 - dsc_pkg::MOD_W){1'b0}}, want}) begin
            $error("modulus readback: expected %0d, actual %0d", want, rd);
            error_count++;
        end
    endtask

    // Write the modulus with junk in the unused upper bits, then read it back.
    task automatic set_modulus(input logic [dsc_pkg::MOD_W-1:0] mod);
        logic [31:0] word;
        logic [31:0] rd;
        word = $urandom();
        word[dsc_pkg::MOD_W-1:0] = mod;
        apb_xfer(1'b1, word, rd);
        cur_modulus = mod;
        setting_count++;
        check_modulus_reg(mod);
    endtask

    // Hold until every queued transaction is taken and answered, then let the pipe settle.
    task automatic drain();
        while (accepted_count != queued_count || expected_counts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly well-formed sequences of random length; some get flipped flags as noise.
    task automatic queue_random_items(input int n_items, input bit join_prev);
        int          left;
        int          len;
        int          i;
        bit          noisy;
        bit          open_seq;
        logic        fst;
        logic        lst;
        int unsigned m;
        left     = n_items;
        open_seq = join_prev;
        m        = effective_mod(cur_modulus);
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
            if (len > left) len = left;
            noisy = ($urandom_range(0, 4) == 0);
            for (i = 0; i < len; i++) begin
                fst = (i == 0) && !open_seq;
                lst = (i == len - 1);
                if (noisy && $urandom_range(0, 5) == 0) fst = ~fst;
                if (noisy && $urandom_range(0, 5) == 0) lst = ~lst;
                queue_item(pick_value(m), fst, lst);
            end
            open_seq = 1'b0;
            left -= len;
        end
    endtask

    // Driver: retire the accepted transaction into the shadow model, then offer the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tally_item(offer);
                accepted_count++;
            end
            // only touch the payload once the slot is free; valid holds otherwise
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    offer    = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_value <= offer.value;
                    s_first <= offer.first;
                    s_last  <= offer.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        run_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                checked_count++;
                if (expected_counts.size() == 0) begin
                    $error("unexpected result: run_count %0d final_res %0b",
                           m_run_count, m_final_res);
                    error_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_run_count !== want.run_count) begin
                        $error("run_count: expected %0d, actual %0d",
                               want.run_count, m_run_count);
                        error_count++;
                    end
                    if (m_final_res !== want.final_res) begin
                        $error("final_res: expected %0b, actual %0b",
                               want.final_res, m_final_res);
                        error_count++;
                    end
                end
            end
            // one long back-pressure stretch, counted here, while the sender keeps going
            if (press_armed && !press_taken) begin
                press_taken  = 1'b1;
                holdoff_left = HOLDOFF;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: the slowest legal run stays far below this.
    initial begin
        #400_000;
        $display("timeout: %0d of %0d transactions answered", checked_count, queued_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int i;
        int unsigned m;

        for (i = 0; i < MAX_MOD; i++) bin_count[i] = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        check_modulus_reg(dsc_pkg::MOD_RESET);

        // reset state acts as a fresh sequence: no first flag, reset modulus
        queue_item(32'h0000_0000, 1'b0, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(32'h0000_0005, 1'b0, 1'b1);
        drain();

        // modulus zero behaves as one
        set_modulus(13'd0);
        queue_item(32'd7, 1'b1, 1'b0);
        queue_item(32'd0, 1'b0, 1'b0);
        queue_item(32'd1, 1'b0, 1'b1);
        drain();

        // largest legal modulus
        set_modulus(13'd4096);
        queue_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_item(32'd1, 1'b0, 1'b0);
        queue_item(32'd4095, 1'b0, 1'b0);
        queue_item(32'd4096, 1'b0, 1'b0);
        queue_item(32'd0, 1'b0, 1'b1);
        drain();

        // above the histogram size: clamps
        set_modulus(13'h1FFF);
        queue_item(32'd12288, 1'b1, 1'b0);
        queue_item(32'd12, 1'b0, 1'b0);
        queue_item(32'hFFFF_F000, 1'b0, 1'b1);
        drain();

        // leave this sequence open, then change the modulus under it
        set_modulus(13'd7);
        queue_item(32'd3, 1'b1, 1'b0);
        queue_item(32'd4, 1'b0, 1'b0);
        queue_item(32'd7, 1'b0, 1'b0);
        queue_item(32'd14, 1'b0, 1'b0);
        queue_item(32'd0, 1'b0, 1'b0);
        drain();

        set_modulus(13'd5);
        queue_item(32'd2, 1'b0, 1'b0);
        queue_item(32'd3, 1'b0, 1'b0);
        queue_item(32'd10, 1'b0, 1'b1);
        queue_item(32'd9, 1'b1, 1'b1);
        drain();

        // random phases across a spread of modulus settings
        set_modulus(13'd2);
        queue_random_items(20, 1'b0);
        drain();

        set_modulus(13'd3);
        queue_random_items(20, 1'b1);
        drain();

        // no idling on either side for a whole phase
        steady_flow = 1'b1;
        set_modulus(13'd6);
        queue_random_items(25, 1'b0);
        drain();
        steady_flow = 1'b0;

        // stall the receiver long enough to back the block up
        set_modulus(13'd13);
        press_armed = 1'b1;
        queue_random_items(20, 1'b0);
        drain();

        set_modulus(13'd1);
        queue_random_items(15, 1'b1);
        drain();

        set_modulus(13'd4096);
        queue_random_items(20, 1'b0);
        drain();

        set_modulus(13'($urandom_range(1, 64)));
        queue_random_items(20, 1'b1);
        drain();

        set_modulus(13'($urandom_range(0, 8191)));
        queue_random_items(20, 1'b0);
        drain();

        set_modulus(13'd0);
        queue_random_items(15, 1'b1);
        drain();

        // many one-element sequences to push the sequence counter past its wrap
        set_modulus(13'($urandom_range(1, 64)));
        m = effective_mod(cur_modulus);
        for (i = 0; i < 260; i++) queue_item(pick_value(m), 1'b1, 1'b1);
        drain();

        $display("covered %0d transactions in %0d sequences over %0d modulus settings",
                 accepted_count, seq_count, setting_count);
        $display("checked %0d result transactions, %0d mismatches", checked_count, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/dsc_pkg.sv
hdl/dsc_cfg_regs.sv
hdl/dsc_ctrl.sv
hdl/dsc_datapath.sv
hdl/divisible_subarray_counter_core.sv
hdl/dsc_checker.sv
tb/divisible_subarray_counter_core_test.sv
